/* src/fti_pkg.sv */
// shared types and constants of the frequency table interpolator
`timescale 1ns / 1ps
package fti_pkg;

    localparam int DEF_MAX_POINTS     = 32;
    localparam int DEF_MAX_CONDUCTORS = 4;

    localparam logic [1:0] CMD_WFREQ = 2'd0;
    localparam logic [1:0] CMD_WELEM = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_TABLE = 2'd1;
    localparam logic [1:0] ST_NO_MATCH = 2'd2;

    localparam logic [1:0] REG_POINT_COUNT     = 2'd0;
    localparam logic [1:0] REG_CONDUCTOR_COUNT = 2'd1;
    localparam logic [1:0] REG_INTERP_ENABLE   = 2'd2;

    localparam logic [16:0] W_ONE = 17'h10000;

    typedef enum logic [1:0] {
        OP_WFREQ,
        OP_WELEM,
        OP_QUERY
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [4:0]         point;
        logic [1:0]         kind;
        logic [3:0]         element;
        logic signed [31:0] value;
        logic [39:0]        freq;
    } t_qent;

    typedef struct packed {
        logic [5:0] point_count;
        logic [2:0] conductor_count;
        logic       interp_enable;
    } t_cfg;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SCAN_RD,
        B_SCAN_CHK,
        B_PICK,
        B_WSET,
        B_DIV,
        B_EL_RD,
        B_EL_MUL,
        B_EL_OUT,
        B_STAT
    } t_bstate;

endpackage

/* src/fti_front.sv */
// front end: accepts words, drops ignored commands, queues the rest
`timescale 1ns / 1ps
module fti_front import fti_pkg::*; #(
    parameter int MAX_POINTS = DEF_MAX_POINTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_cmd,
    input  logic [4:0]         i_point,
    input  logic [1:0]         i_matrix_kind,
    input  logic [3:0]         i_element,
    input  logic signed [31:0] i_value,
    input  logic [39:0]        i_freq,
    output logic               o_q_valid,
    input  logic               i_q_pop,
    output t_qent              o_q_ent
);

    t_qent      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       keep, push;
    t_qent      ent;

    always_comb begin
        ent.point   = i_point;
        ent.kind    = i_matrix_kind;
        ent.element = i_element;
        ent.value   = i_value;
        ent.freq    = i_freq;
        ent.op      = OP_QUERY;
        keep        = 1'b0;
        case (i_cmd)
            CMD_WFREQ: begin
                ent.op = OP_WFREQ;
                keep   = 11'(i_point) < 11'(MAX_POINTS);
            end
            CMD_WELEM: begin
                ent.op = OP_WELEM;
                keep   = 11'(i_point) < 11'(MAX_POINTS);
            end
            CMD_QUERY: begin
                ent.op = OP_QUERY;
                keep   = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign push      = i_valid && o_ready && keep;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_ent   = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_q_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && i_q_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= ent;
        end
    end

endmodule

/* src/fti_back.sv */
// back end: table memories, scan, weight divider, blend and result register
`timescale 1ns / 1ps
module fti_back import fti_pkg::*; #(
    parameter int MAX_POINTS     = DEF_MAX_POINTS,
    parameter int MAX_CONDUCTORS = DEF_MAX_CONDUCTORS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_q_valid,
    output logic               o_q_pop,
    input  t_qent              i_q_ent,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [3:0]         o_out_element,
    output logic signed [31:0] o_r_value,
    output logic signed [31:0] o_l_value,
    output logic signed [31:0] o_c_value,
    output logic signed [31:0] o_g_value,
    output logic [1:0]         o_status,
    output logic               o_last
);

    localparam int PW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int SD  = MAX_POINTS * 16;
    localparam int SAW = PW + 4;

    t_bstate r_state, n_state;

    logic [39:0] r_fmem [MAX_POINTS];
    logic [31:0] r_smem [4][SD];

    // config decode
    logic [CW-1:0] cnt, cm1, cm2;
    logic [2:0]    nc;
    logic [3:0]    size_m1;
    logic [10:0]   pc_w;

    always_comb begin
        pc_w = 11'(i_cfg.point_count);
        cnt  = (pc_w > 11'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(pc_w);
        cm1  = cnt - CW'(1);
        cm2  = cnt - CW'(2);
        if (i_cfg.conductor_count == 3'd0) begin
            nc = 3'd1;
        end else if (i_cfg.conductor_count > 3'(MAX_CONDUCTORS)) begin
            nc = 3'(MAX_CONDUCTORS);
        end else begin
            nc = i_cfg.conductor_count;
        end
        size_m1 = 4'(({2'b00, nc} * {2'b00, nc}) - 5'd1);
    end

    // query working registers
    logic [39:0]   r_f, r_rd, r_t0, r_t1, r_prev, r_pp, r_bflo, r_bfhi, r_flo, r_fhi;
    logic [CW-1:0] r_idx;
    logic          r_found, r_brk;
    logic [PW-1:0] r_match, r_blo, r_lo, r_hi;
    logic [16:0]   r_w;
    logic [14:0]   r_q;
    logic [39:0]   r_rem, r_den;
    logic [3:0]    r_dcnt, r_k;
    logic [1:0]    r_stat;
    logic [31:0]   r_a [4];
    logic [31:0]   r_b [4];
    logic signed [50:0] r_prod [4];

    // result register
    logic               r_ov, r_olast;
    logic [3:0]         r_oel;
    logic [31:0]        r_oval [4];
    logic [1:0]         r_ost;

    logic out_free;
    assign out_free = !r_ov || i_ready;

    // weight setup
    logic [40:0] num, den;
    logic [39:0] an, ad;
    logic        w_zero, w_one;

    always_comb begin
        num    = {1'b0, r_f} - {1'b0, r_flo};
        den    = {1'b0, r_fhi} - {1'b0, r_flo};
        an     = num[40] ? 40'(-num) : num[39:0];
        ad     = den[40] ? 40'(-den) : den[39:0];
        w_zero = (num == 41'd0) || (den == 41'd0) || (num[40] != den[40]);
        w_one  = (an >= ad);
    end

    // one restoring division step
    logic [40:0] rem2;
    logic        q_bit;
    assign rem2  = {r_rem, 1'b0};
    assign q_bit = rem2 >= {1'b0, r_den};

    // blend datapath
    logic signed [32:0] diff_c [4];
    logic signed [50:0] prod_c [4];
    logic [31:0]        sum_c  [4];

    always_comb begin
        for (int m = 0; m < 4; m++) begin
            diff_c[m] = $signed({r_b[m][31], r_b[m]}) - $signed({r_a[m][31], r_a[m]});
            prod_c[m] = 51'($signed({1'b0, r_w}) * diff_c[m]);
            // floor shift by 16 is an arithmetic shift
            sum_c[m]  = r_a[m] + r_prod[m][47:16];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_q_valid && i_q_ent.op == OP_QUERY) begin
                    n_state = (cnt == CW'(0)) ? B_STAT : B_SCAN_RD;
                end
            end
            B_SCAN_RD:  n_state = B_SCAN_CHK;
            B_SCAN_CHK: n_state = (r_idx == cm1) ? B_PICK : B_SCAN_RD;
            B_PICK: begin
                if (r_found) begin
                    n_state = B_EL_RD;
                end else if (!i_cfg.interp_enable || cnt < CW'(2)) begin
                    n_state = B_STAT;
                end else begin
                    n_state = B_WSET;
                end
            end
            B_WSET:   n_state = (w_zero || w_one) ? B_EL_RD : B_DIV;
            B_DIV:    n_state = (r_dcnt == 4'd15) ? B_EL_RD : B_DIV;
            B_EL_RD:  n_state = B_EL_MUL;
            B_EL_MUL: n_state = B_EL_OUT;
            B_EL_OUT: begin
                if (out_free) begin
                    n_state = (r_k == size_m1) ? B_IDLE : B_EL_RD;
                end
            end
            B_STAT:   n_state = out_free ? B_IDLE : B_STAT;
            default:  n_state = B_IDLE;
        endcase
    end

    // state outputs
    logic f_we, s_we, o_load;
    always_comb begin
        o_q_pop = 1'b0;
        f_we    = 1'b0;
        s_we    = 1'b0;
        o_load  = 1'b0;
        case (r_state)
            B_IDLE: begin
                o_q_pop = i_q_valid;
                f_we    = i_q_valid && i_q_ent.op == OP_WFREQ;
                s_we    = i_q_valid && i_q_ent.op == OP_WELEM;
            end
            B_EL_OUT: o_load = out_free;
            B_STAT:   o_load = out_free;
            default:  o_q_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // table memories
    logic [10:0]    pt_w;
    logic [SAW-1:0] w_addr, a_addr, b_addr;
    assign pt_w   = 11'(i_q_ent.point);
    assign w_addr = {pt_w[PW-1:0], i_q_ent.element};
    assign a_addr = {r_lo, r_k};
    assign b_addr = {r_hi, r_k};

    always_ff @(posedge i_clk) begin
        if (f_we) begin
            r_fmem[pt_w[PW-1:0]] <= i_q_ent.freq;
        end
        if (r_state == B_SCAN_RD) begin
            r_rd <= r_fmem[r_idx[PW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int m = 0; m < 4; m++) begin
            if (s_we && i_q_ent.kind == 2'(m)) begin
                r_smem[m][w_addr] <= i_q_ent.value;
            end
            if (r_state == B_EL_RD) begin
                r_a[m] <= r_smem[m][a_addr];
                r_b[m] <= r_smem[m][b_addr];
            end
        end
    end

    // query datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_f     <= i_q_ent.freq;
                r_idx   <= '0;
                r_found <= 1'b0;
                r_brk   <= 1'b0;
                r_k     <= 4'd0;
                r_stat  <= ST_NO_TABLE;
            end
            B_SCAN_CHK: begin
                if (r_idx == CW'(0)) begin
                    r_t0 <= r_rd;
                end
                if (r_idx == CW'(1)) begin
                    r_t1 <= r_rd;
                end
                if (!r_found && r_rd == r_f) begin
                    r_found <= 1'b1;
                    r_match <= r_idx[PW-1:0];
                end
                // first bracketing pair
                if (r_idx != CW'(0) && !r_brk && r_prev <= r_f && r_f <= r_rd) begin
                    r_brk  <= 1'b1;
                    r_blo  <= PW'(r_idx - CW'(1));
                    r_bflo <= r_prev;
                    r_bfhi <= r_rd;
                end
                r_pp   <= r_prev;
                r_prev <= r_rd;
                r_idx  <= r_idx + CW'(1);
            end
            B_PICK: begin
                r_stat <= ST_NO_MATCH;
                r_w    <= 17'd0;
                if (r_found) begin
                    r_lo <= r_match;
                    r_hi <= r_match;
                end else if (r_f < r_t0) begin
                    r_lo  <= PW'(0);
                    r_hi  <= PW'(1);
                    r_flo <= r_t0;
                    r_fhi <= r_t1;
                end else if (r_f > r_prev) begin
                    r_lo  <= cm2[PW-1:0];
                    r_hi  <= cm1[PW-1:0];
                    r_flo <= r_pp;
                    r_fhi <= r_prev;
                end else if (r_brk) begin
                    r_lo  <= r_blo;
                    r_hi  <= r_blo + PW'(1);
                    r_flo <= r_bflo;
                    r_fhi <= r_bfhi;
                end else begin
                    r_lo  <= PW'(0);
                    r_hi  <= cm1[PW-1:0];
                    r_flo <= r_t0;
                    r_fhi <= r_prev;
                end
            end
            B_WSET: begin
                r_w    <= w_zero ? 17'd0 : W_ONE;
                r_rem  <= an;
                r_den  <= ad;
                r_dcnt <= 4'd0;
            end
            B_DIV: begin
                r_rem  <= q_bit ? 40'(rem2 - {1'b0, r_den}) : rem2[39:0];
                r_q    <= {r_q[13:0], q_bit};
                r_dcnt <= r_dcnt + 4'd1;
                if (r_dcnt == 4'd15) begin
                    r_w <= {1'b0, r_q[14:0], q_bit};
                end
            end
            B_EL_MUL: begin
                for (int m = 0; m < 4; m++) begin
                    r_prod[m] <= prod_c[m];
                end
            end
            B_EL_OUT: begin
                if (out_free) begin
                    r_k <= r_k + 4'd1;
                end
            end
            default: r_k <= r_k;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (o_load) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            if (r_state == B_STAT) begin
                r_oel   <= 4'd0;
                r_ost   <= r_stat;
                r_olast <= 1'b1;
                for (int m = 0; m < 4; m++) begin
                    r_oval[m] <= 32'd0;
                end
            end else begin
                r_oel   <= r_k;
                r_ost   <= ST_OK;
                r_olast <= (r_k == size_m1);
                for (int m = 0; m < 4; m++) begin
                    r_oval[m] <= sum_c[m];
                end
            end
        end
    end

    assign o_valid       = r_ov;
    assign o_out_element = r_oel;
    assign o_r_value     = r_oval[0];
    assign o_l_value     = r_oval[1];
    assign o_c_value     = r_oval[2];
    assign o_g_value     = r_oval[3];
    assign o_status      = r_ost;
    assign o_last        = r_olast;

endmodule

/* src/freq_table_matrix_interpolator_top.sv */
// top level: config registers, front queue and back end of the interpolator
//
//  channel   direction  handshake          payload
//  input     in         i_valid/o_ready    cmd, point, matrix_kind, element, value, freq
//  result    out        o_valid/i_ready    out_element, r/l/c/g values, status, last
//  config    in         psel/penable       paddr, pwdata, prdata (apb)
//
// a write word is taken by the back end straight from idle; a query reads and checks each point
// in use in the frequency scan, picks the bracket, sets up the weight when interpolating and runs
// the divider unless the weight is 0 or 1, then passes each result word through the store
// read, multiply and add stages
// synchronous active-low reset clears control state; memories hold garbage until written
// the input queue is two words deep, so the front can take up to two words while results stall
`timescale 1ns / 1ps
module freq_table_matrix_interpolator_top import fti_pkg::*; #(
    parameter int MAX_POINTS     = DEF_MAX_POINTS,
    parameter int MAX_CONDUCTORS = DEF_MAX_CONDUCTORS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_cmd,
    input  logic [4:0]         i_point,
    input  logic [1:0]         i_matrix_kind,
    input  logic [3:0]         i_element,
    input  logic signed [31:0] i_value,
    input  logic [39:0]        i_freq,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [3:0]         o_out_element,
    output logic signed [31:0] o_r_value,
    output logic signed [31:0] o_l_value,
    output logic signed [31:0] o_c_value,
    output logic signed [31:0] o_g_value,
    output logic [1:0]         o_status,
    output logic               o_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_cfg  r_cfg;
    logic  q_valid, q_pop;
    t_qent q_ent;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.point_count     <= 6'd0;
            r_cfg.conductor_count <= 3'd1;
            r_cfg.interp_enable   <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_POINT_COUNT:     r_cfg.point_count     <= pwdata[5:0];
                REG_CONDUCTOR_COUNT: r_cfg.conductor_count <= pwdata[2:0];
                REG_INTERP_ENABLE:   r_cfg.interp_enable   <= pwdata[0];
                default:             r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_POINT_COUNT:     prdata = 32'(r_cfg.point_count);
            REG_CONDUCTOR_COUNT: prdata = 32'(r_cfg.conductor_count);
            REG_INTERP_ENABLE:   prdata = 32'(r_cfg.interp_enable);
            default:             prdata = 32'd0;
        endcase
    end

    fti_front #(
        .MAX_POINTS(MAX_POINTS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_point       (i_point),
        .i_matrix_kind (i_matrix_kind),
        .i_element     (i_element),
        .i_value       (i_value),
        .i_freq        (i_freq),
        .o_q_valid     (q_valid),
        .i_q_pop       (q_pop),
        .o_q_ent       (q_ent)
    );

    fti_back #(
        .MAX_POINTS     (MAX_POINTS),
        .MAX_CONDUCTORS (MAX_CONDUCTORS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (q_valid),
        .o_q_pop       (q_pop),
        .i_q_ent       (q_ent),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_element (o_out_element),
        .o_r_value     (o_r_value),
        .o_l_value     (o_l_value),
        .o_c_value     (o_c_value),
        .o_g_value     (o_g_value),
        .o_status      (o_status),
        .o_last        (o_last)
    );

endmodule

/* dv/tb_freq_table_matrix_interpolator_top.sv */
// testbench of the frequency table matrix interpolator: directed and random words checked against a predictor
`timescale 1ns / 1ps
module tb_freq_table_matrix_interpolator_top;
    import fti_pkg::*;

    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam logic [1:0] KIND_R = 2'd0;
    localparam logic [1:0] KIND_L = 2'd1;
    localparam logic [1:0] KIND_C = 2'd2;
    localparam logic [1:0] KIND_G = 2'd3;
    localparam int SETTLE_CYCLES = 250;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [4:0]  point;
        logic [1:0]  kind;
        logic [3:0]  element;
        logic [31:0] value;
        logic [39:0] freq;
    } t_word;

    typedef struct packed {
        logic [3:0]  element;
        logic [31:0] r;
        logic [31:0] l;
        logic [31:0] c;
        logic [31:0] g;
        logic [1:0]  status;
        logic        last;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [1:0] i_cmd = '0;
    logic [4:0] i_point = '0;
    logic [1:0] i_matrix_kind = '0;
    logic [3:0] i_element = '0;
    logic signed [31:0] i_value = '0;
    logic [39:0] i_freq = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [3:0] o_out_element;
    logic signed [31:0] o_r_value, o_l_value, o_c_value, o_g_value;
    logic [1:0] o_status;
    logic o_last;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    freq_table_matrix_interpolator_top dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state, updated as words are accepted
    logic [39:0] tab_freq [32];
    logic signed [31:0] tab_val [4][512];
    logic [5:0] cfg_points = 6'd0;
    logic [2:0] cfg_cond = 3'd1;
    logic cfg_interp = 1'b0;

    // generator view, used to read only entries already written
    logic [39:0] gen_freq [32];
    bit gen_fset [32];
    bit gen_eset [4][512];

    t_word pending_words [$];
    t_row matrix_rows [$];
    t_word cur;
    int errors = 0;
    int gap_cnt = 0;
    int stall_cnt = 0;
    int hold_cnt = 0;
    int rows_seen = 0;
    bit held = 1'b0;
    bit quiet = 1'b0;

    function automatic logic [31:0] blend_value(logic signed [31:0] lo, logic signed [31:0] hi,
                                                logic [16:0] wt);
        longint p;
        p = longint'(wt) * (longint'(hi) - longint'(lo));
        return 32'(longint'(lo) + (p >>> 16));
    endfunction

    function automatic t_row status_row(logic [1:0] st);
        t_row r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic void apply_word(t_word w);
        int cnt, n, sz, lo, hi;
        bit found;
        logic [16:0] wt;
        longint num, den;
        t_row r;
        case (w.cmd)
            CMD_WFREQ: tab_freq[w.point] = w.freq;
            CMD_WELEM: tab_val[w.kind][{w.point, w.element}] = w.value;
            CMD_QUERY: begin
                cnt = cfg_points > 32 ? 32 : int'(cfg_points);
                n = cfg_cond == 0 ? 1 : (cfg_cond > 4 ? 4 : int'(cfg_cond));
                sz = n * n;
                found = 1'b0;
                lo = 0;
                hi = 0;
                wt = '0;
                if (cnt == 0) begin
                    matrix_rows.push_back(status_row(ST_NO_TABLE));
                end else begin
                    for (int i = 0; i < cnt; i++) begin
                        if (!found && tab_freq[i] == w.freq) begin
                            lo = i;
                            hi = i;
                            found = 1'b1;
                        end
                    end
                    if (!found && (!cfg_interp || cnt < 2)) begin
                        matrix_rows.push_back(status_row(ST_NO_MATCH));
                    end else begin
                        if (!found) begin
                            if (w.freq < tab_freq[0]) begin
                                lo = 0;
                                hi = 1;
                            end else if (w.freq > tab_freq[cnt-1]) begin
                                lo = cnt - 2;
                                hi = cnt - 1;
                            end else begin
                                lo = 0;
                                hi = cnt - 1;
                                for (int i = cnt - 2; i >= 0; i--) begin
                                    if (w.freq >= tab_freq[i] && w.freq <= tab_freq[i+1]) begin
                                        lo = i;
                                        hi = i + 1;
                                    end
                                end
                            end
                            num = longint'(w.freq) - longint'(tab_freq[lo]);
                            den = longint'(tab_freq[hi]) - longint'(tab_freq[lo]);
                            if (den == 0 || num == 0 || ((num < 0) != (den < 0))) begin
                                wt = '0;
                            end else begin
                                if (num < 0) num = -num;
                                if (den < 0) den = -den;
                                wt = num >= den ? W_ONE : 17'((num << 16) / den);
                            end
                        end
                        for (int k = 0; k < sz; k++) begin
                            r.element = 4'(k);
                            r.r = blend_value(tab_val[KIND_R][lo*16+k], tab_val[KIND_R][hi*16+k], wt);
                            r.l = blend_value(tab_val[KIND_L][lo*16+k], tab_val[KIND_L][hi*16+k], wt);
                            r.c = blend_value(tab_val[KIND_C][lo*16+k], tab_val[KIND_C][hi*16+k], wt);
                            r.g = blend_value(tab_val[KIND_G][lo*16+k], tab_val[KIND_G][hi*16+k], wt);
                            r.status = ST_OK;
                            r.last = (k == sz - 1);
                            matrix_rows.push_back(r);
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) apply_word(cur);
            if (!i_valid || o_ready) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                    i_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    cur = pending_words.pop_front();
                    i_cmd <= cur.cmd;
                    i_point <= cur.point;
                    i_matrix_kind <= cur.kind;
                    i_element <= cur.element;
                    i_value <= cur.value;
                    i_freq <= cur.freq;
                    i_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 4) == 0) gap_cnt = $urandom_range(1, 11);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver, with one long hold-off to back the block up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) rows_seen++;
            if (!held && rows_seen >= 60) begin
                held = 1'b1;
                hold_cnt = 400;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_ready <= 1'b0;
            end else if (quiet) begin
                i_ready <= 1'b1;
            end else if (stall_cnt > 0) begin
                stall_cnt--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if ($urandom_range(0, 5) == 0) stall_cnt = $urandom_range(1, 11);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_row e;
        if (i_rst_n && o_valid && i_ready) begin
            if (matrix_rows.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                e = matrix_rows.pop_front();
                if (o_out_element !== e.element) begin
                    $error("out_element exp %0d got %0d", e.element, o_out_element);
                    errors++;
                end
                if (o_r_value !== e.r) begin
                    $error("r_value exp %0d got %0d", $signed(e.r), o_r_value);
                    errors++;
                end
                if (o_l_value !== e.l) begin
                    $error("l_value exp %0d got %0d", $signed(e.l), o_l_value);
                    errors++;
                end
                if (o_c_value !== e.c) begin
                    $error("c_value exp %0d got %0d", $signed(e.c), o_c_value);
                    errors++;
                end
                if (o_g_value !== e.g) begin
                    $error("g_value exp %0d got %0d", $signed(e.g), o_g_value);
                    errors++;
                end
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status);
                    errors++;
                end
                if (o_last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, o_last);
                    errors++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic add_word(logic [1:0] cmd, logic [4:0] pt, logic [1:0] kind,
                            logic [3:0] el, logic [31:0] val, logic [39:0] f);
        t_word w;
        w = '{cmd, pt, kind, el, val, f};
        if (cmd == CMD_WFREQ) begin
            gen_freq[pt] = f;
            gen_fset[pt] = 1'b1;
        end
        if (cmd == CMD_WELEM) gen_eset[kind][{pt, el}] = 1'b1;
        pending_words.push_back(w);
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || i_valid || matrix_rows.size() != 0)
            @(posedge i_clk);
        // writes give no result, let the back end drain
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] d);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_POINT_COUNT:     cfg_points = d[5:0];
            REG_CONDUCTOR_COUNT: cfg_cond = d[2:0];
            default:             cfg_interp = d[0];
        endcase
    endtask

    task automatic set_config(int pc, int cc, int ie);
        wait_idle();
        reg_write(REG_POINT_COUNT, pc);
        reg_write(REG_CONDUCTOR_COUNT, cc);
        reg_write(REG_INTERP_ENABLE, ie);
    endtask

    // phase of random words; table loaded first so queries read written entries only
    task automatic random_phase(int pc, int cc, int ie, int nwords, bit sorted);
        int cnt, n, sz, pick, i;
        logic [39:0] f, step;
        set_config(pc, cc, ie);
        cnt = pc > 32 ? 32 : pc;
        n = cc == 0 ? 1 : (cc > 4 ? 4 : cc);
        sz = n * n;
        f = {$urandom_range(0, 255), $urandom()};
        for (int p = 0; p < cnt; p++) begin
            if (sorted) begin
                step = $urandom_range(0, 7) == 0 ? 40'd0 : 40'($urandom_range(1, 100000));
                f = f + step;
                add_word(CMD_WFREQ, p, 0, 0, $urandom(), f);
            end else if (!gen_fset[p] || $urandom_range(0, 1)) begin
                add_word(CMD_WFREQ, p, 0, 0, $urandom(), {$urandom_range(0, 255), $urandom()});
            end
            for (int e = 0; e < sz; e++)
                for (int k = 0; k < 4; k++)
                    if (!gen_eset[k][p*16+e]) add_word(CMD_WELEM, p, k, e, $urandom(), $urandom());
        end
        for (int j = 0; j < nwords; j++) begin
            pick = $urandom_range(0, 99);
            i = cnt > 0 ? $urandom_range(0, cnt - 1) : 0;
            if (pick < 50) begin
                case ($urandom_range(0, 5))
                    0: f = gen_freq[i];
                    1: f = gen_freq[i] + 40'($urandom_range(0, 50000)) - 40'd25000;
                    2: f = {$urandom(), $urandom()};
                    3: f = $urandom_range(0, 1) ? 40'd0 : '1;
                    default: f = (gen_freq[i] >> 1) + (gen_freq[cnt > 0 ? cnt - 1 : 0] >> 1);
                endcase
                add_word(CMD_QUERY, $urandom(), $urandom(), $urandom(), $urandom(), f);
            end else if (pick < 75) begin
                add_word(CMD_WELEM, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
            end else if (pick < 94) begin
                if ($urandom_range(0, 1))
                    add_word(CMD_WFREQ, $urandom(), $urandom(), $urandom(), $urandom(),
                             {$urandom(), $urandom()});
                else
                    add_word(CMD_WFREQ, i, 0, 0, 0, gen_freq[i] + 40'($urandom_range(0, 9)));
            end else begin
                add_word(CMD_SPARE, $urandom(), $urandom(), $urandom(), $urandom(),
                         {$urandom(), $urandom()});
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no table, spare command ignored
        set_config(0, 1, 0);
        add_word(CMD_QUERY, 0, 0, 0, 0, 40'd0);
        add_word(CMD_SPARE, 5'd31, KIND_G, 4'd15, 32'h7fffffff, '1);

        // two points, extreme values, exact hits and interpolation both sides
        set_config(2, 1, 1);
        add_word(CMD_WFREQ, 0, 0, 0, 0, 40'd1000);
        add_word(CMD_WFREQ, 1, 0, 0, 0, 40'd2000);
        add_word(CMD_WELEM, 0, KIND_R, 0, 32'h7fffffff, 0);
        add_word(CMD_WELEM, 1, KIND_R, 0, 32'h80000000, 0);
        add_word(CMD_WELEM, 0, KIND_L, 0, -32'sd5, 0);
        add_word(CMD_WELEM, 1, KIND_L, 0, 32'sd7, 0);
        add_word(CMD_WELEM, 0, KIND_C, 0, 0, 0);
        add_word(CMD_WELEM, 1, KIND_C, 0, 0, 0);
        add_word(CMD_WELEM, 0, KIND_G, 0, 32'sd9, 0);
        add_word(CMD_WELEM, 1, KIND_G, 0, -32'sd3, 0);
        add_word(CMD_QUERY, 0, 0, 0, 0, 40'd1000);
        add_word(CMD_QUERY, 0, 0, 0, 0, 40'd2000);
        add_word(CMD_QUERY, 0, 0, 0, 0, 40'd1500);
        add_word(CMD_QUERY, 0, 0, 0, 0, 40'd1001);
        add_word(CMD_QUERY, 0, 0, 0, 0, 40'd0);
        add_word(CMD_QUERY, 0, 0, 0, 0, '1);

        // interpolation off, then a single point in use
        set_config(2, 1, 0);
        add_word(CMD_QUERY, 0, 0, 0, 0, 40'd1500);
        add_word(CMD_QUERY, 0, 0, 0, 0, 40'd1000);
        set_config(1, 1, 1);
        add_word(CMD_QUERY, 0, 0, 0, 0, 40'd1500);

        // duplicate frequency: first point wins; above the end with a flat bracket
        set_config(3, 1, 1);
        add_word(CMD_WFREQ, 2, 0, 0, 0, 40'd2000);
        for (int k = 0; k < 4; k++) add_word(CMD_WELEM, 2, k, 0, $urandom(), 0);
        add_word(CMD_QUERY, 0, 0, 0, 0, 40'd2000);
        add_word(CMD_QUERY, 0, 0, 0, 0, 40'd2500);

        random_phase(4, 2, 1, 15, 1'b1);
        random_phase(1, 7, 1, 12, 1'b1);
        random_phase(63, 0, 1, 12, 1'b1);
        random_phase(5, 1, 0, 10, 1'b0);
        random_phase(4, 1, 1, 10, 1'b0);
        random_phase(0, 4, 1, 6, 1'b0);
        wait_idle();
        quiet = 1'b1;
        random_phase(3, 2, 1, 15, 1'b1);
        wait_idle();

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
